// ===== hdl/bfea_pkg.sv =====
// Shared types and constants for the bitmap free-entry allocator.
// No dependencies; every other file but bfea_ram imports this package.
package bfea_pkg;

   localparam int ENTRY_W   = 12;
   localparam int CMD_W     = 2;
   localparam int WORD_BITS = 32;
   localparam int OFFSET_W  = 5;
   localparam int MAX_WORDS = 128;
   localparam int GROUP_N   = 16;
   localparam int GROUP_W   = 4;

   localparam logic [CMD_W-1:0] CMD_MARK_USED = 2'd0;
   localparam logic [CMD_W-1:0] CMD_MARK_FREE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FIND_FREE = 2'd2;

   typedef struct packed {
      logic                found;
      logic [OFFSET_W-1:0] offset;
   } scan_result_type;

endpackage

// ===== hdl/bfea_req_if.sv =====
// Command channel: valid/ready handshake carrying one command word.
// Depends on bfea_pkg.
interface bfea_req_if
   import bfea_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic [ENTRY_W-1:0] entry_index;

   modport source (output valid, output command, output entry_index, input ready);
   modport sink (input valid, input command, input entry_index, output ready);
endinterface

// ===== hdl/bfea_rsp_if.sv =====
// Result channel: valid/ready handshake carrying one result word.
// Depends on bfea_pkg.
interface bfea_rsp_if
   import bfea_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [ENTRY_W-1:0] free_index;
   logic               found;

   modport source (output valid, output free_index, output found, input ready);
   modport sink (input valid, input free_index, input found, output ready);
endinterface

// ===== hdl/bfea_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module bfea_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hdl/bfea_first_free.sv =====
// Finds the lowest free entry offset at or above a start offset in one map word.
// Entries are MSB first. Depends on bfea_pkg.
module bfea_first_free
   import bfea_pkg::*;
(
   input  logic [WORD_BITS-1:0] word,
   input  logic [OFFSET_W-1:0]  start,
   output scan_result_type      result
);
   always_comb begin
      result = '0;
      for (int j = WORD_BITS - 1; j >= 0; j--) begin
         if (!word[WORD_BITS-1-j] && (OFFSET_W'(j) >= start)) begin
            result.found  = 1'b1;
            result.offset = OFFSET_W'(j);
         end
      end
   end
endmodule

// ===== hdl/bitmap_free_entry_allocator_unit.sv =====
// Bitmap free-entry allocator top level.
// Depends on bfea_pkg, bfea_req_if, bfea_rsp_if, bfea_ram, bfea_first_free.
//
// Usage:
//   req_ch carries a command word (mark entry used, mark entry free, find the
//   lowest free entry at or above first_searchable). rsp_ch returns exactly one
//   result word per command: free_index and found for a find, zeros otherwise.
//   csr_wr_en/csr_wr_data write first_searchable; write it only while idle.
// Sequencing:
//   One command at a time: req_ch is ready only in the idle state. A mark reads
//   its word, then writes it back with the bit set or cleared. A find reads the
//   start word and, if no free entry lies at or above first_searchable there,
//   reads the first word above it that a per-word full-summary vector (searched
//   through a registered two-level tree) names as not full. The bitmap RAM has
//   a registered read port.
// Reset:
//   Clears per-word valid and full flags; an unwritten word reads as all free.
//   first_searchable clears to zero. No clearing pass runs.
// Stall:
//   A finished result waits in a holding state until the output register is
//   free; req_ch is not ready until the result has been loaded there.
module bitmap_free_entry_allocator_unit
   import bfea_pkg::*;
#(
   parameter int MAP_WORDS = 128
) (
   input  logic               clock,
   input  logic               reset,
   bfea_req_if.sink           req_ch,
   bfea_rsp_if.source         rsp_ch,
   input  logic               csr_wr_en,
   input  logic [ENTRY_W-1:0] csr_wr_data
);
   localparam int WORDS   = (MAP_WORDS < MAX_WORDS) ? MAP_WORDS : MAX_WORDS;
   localparam int WORD_AW = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int LIMIT   = WORDS * WORD_BITS;
   localparam int NGRP    = (WORDS + GROUP_N - 1) / GROUP_N;
   localparam int WIDX_W  = ENTRY_W - OFFSET_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WORD,
      ST_NEXT,
      ST_FINISH
   } state_type;

   state_type              state_ff, state_in;
   logic [ENTRY_W-1:0]     first_ff, first_in;
   logic [CMD_W-1:0]       cmd_ff, cmd_in;
   logic [OFFSET_W-1:0]    off_ff, off_in;
   logic [WORD_AW-1:0]     addr_ff, addr_in;
   logic [WORDS-1:0]       valid_ff, valid_in;
   logic [WORDS-1:0]       full_ff, full_in;
   logic [NGRP-1:0]        grp_any_ff, grp_any_in;
   logic [GROUP_W-1:0]     grp_off_ff [NGRP];
   logic [GROUP_W-1:0]     grp_off_in [NGRP];
   logic [ENTRY_W-1:0]     res_index_ff, res_index_in;
   logic                   res_found_ff, res_found_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ENTRY_W-1:0]     rsp_index_ff, rsp_index_in;
   logic                   rsp_found_ff, rsp_found_in;

   logic                   ram_wr_en;
   logic [WORD_BITS-1:0]   ram_wr_data;
   logic                   ram_rd_en;
   logic [WORD_AW-1:0]     ram_rd_addr;
   logic [WORD_BITS-1:0]   ram_rd_data;
   logic [WORD_BITS-1:0]   cur_word;
   logic [OFFSET_W-1:0]    scan_start;
   scan_result_type        scan;
   logic [NGRP*GROUP_N-1:0] cand;
   logic [WIDX_W-1:0]      start_word;
   logic                   next_any;
   logic [WORD_AW-1:0]     next_addr;
   logic                   slot_free;

   bfea_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORDS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (addr_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bfea_first_free u_scan (
      .word   (cur_word),
      .start  (scan_start),
      .result (scan)
   );

   assign start_word  = first_ff[ENTRY_W-1:OFFSET_W];
   assign cur_word    = valid_ff[addr_ff] ? ram_rd_data : '0;
   assign scan_start  = (state_ff == ST_WORD) ? first_ff[OFFSET_W-1:0] : '0;
   assign slot_free   = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.free_index = rsp_index_ff;
   assign rsp_ch.found      = rsp_found_ff;

   // candidate words: above the start word and not full
   always_comb begin
      cand = '0;
      for (int w = 0; w < WORDS; w++) begin
         cand[w] = !full_ff[w] && (w > int'(start_word));
      end
   end

   // second level of the word search tree
   always_comb begin
      next_any  = 1'b0;
      next_addr = '0;
      for (int g = NGRP - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            next_any  = 1'b1;
            next_addr = WORD_AW'(g * GROUP_N + int'(grp_off_ff[g]));
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      first_in     = csr_wr_en ? csr_wr_data : first_ff;
      cmd_in       = cmd_ff;
      off_in       = off_ff;
      addr_in      = addr_ff;
      valid_in     = valid_ff;
      full_in      = full_ff;
      grp_any_in   = grp_any_ff;
      grp_off_in   = grp_off_ff;
      res_index_in = res_index_ff;
      res_found_in = res_found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_index_in = rsp_index_ff;
      rsp_found_in = rsp_found_ff;
      ram_wr_en    = 1'b0;
      ram_wr_data  = cur_word;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = addr_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               cmd_in       = req_ch.command;
               off_in       = req_ch.entry_index[OFFSET_W-1:0];
               res_index_in = '0;
               res_found_in = 1'b0;
               state_in     = ST_FINISH;
               for (int g = 0; g < NGRP; g++) begin
                  grp_any_in[g] = 1'b0;
                  grp_off_in[g] = '0;
                  for (int b = GROUP_N - 1; b >= 0; b--) begin
                     if (cand[g*GROUP_N+b]) begin
                        grp_any_in[g] = 1'b1;
                        grp_off_in[g] = GROUP_W'(b);
                     end
                  end
               end
               if ((req_ch.command == CMD_MARK_USED || req_ch.command == CMD_MARK_FREE)
                   && ({1'b0, req_ch.entry_index} < (ENTRY_W+1)'(LIMIT))) begin
                  addr_in     = WORD_AW'(req_ch.entry_index[ENTRY_W-1:OFFSET_W]);
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = addr_in;
                  state_in    = ST_WORD;
               end else if (req_ch.command == CMD_FIND_FREE
                            && ({1'b0, first_ff} < (ENTRY_W+1)'(LIMIT))) begin
                  addr_in     = WORD_AW'(start_word);
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = addr_in;
                  state_in    = ST_WORD;
               end
            end
         end
         ST_WORD: begin
            state_in = ST_FINISH;
            if (cmd_ff == CMD_FIND_FREE) begin
               if (scan.found) begin
                  res_index_in = {WIDX_W'(addr_ff), scan.offset};
                  res_found_in = 1'b1;
               end else if (next_any) begin
                  addr_in     = next_addr;
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = next_addr;
                  state_in    = ST_NEXT;
               end
            end else begin
               if (cmd_ff == CMD_MARK_USED) begin
                  ram_wr_data = cur_word | (32'h8000_0000 >> off_ff);
               end else begin
                  ram_wr_data = cur_word & ~(32'h8000_0000 >> off_ff);
               end
               ram_wr_en         = 1'b1;
               valid_in[addr_ff] = 1'b1;
               full_in[addr_ff]  = &ram_wr_data;
            end
         end
         ST_NEXT: begin
            res_index_in = {WIDX_W'(addr_ff), scan.offset};
            res_found_in = scan.found;
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = res_index_ff;
               rsp_found_in = res_found_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         first_ff     <= '0;
         valid_ff     <= '0;
         full_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         valid_ff     <= valid_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      off_ff       <= off_in;
      addr_ff      <= addr_in;
      grp_any_ff   <= grp_any_in;
      grp_off_ff   <= grp_off_in;
      res_index_ff <= res_index_in;
      res_found_ff <= res_found_in;
      rsp_index_ff <= rsp_index_in;
      rsp_found_ff <= rsp_found_in;
   end
endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for bitmap_free_entry_allocator_unit: directed table, then random phases.
// Depends on bfea_pkg, bfea_req_if, bfea_rsp_if and the allocator RTL under hdl/.
module tb_top;
   import bfea_pkg::*;

   localparam int MAP_WORDS   = 128;
   localparam int ENTRY_LIMIT = (MAP_WORDS * WORD_BITS < 4096) ? MAP_WORDS * WORD_BITS : 4096;
   localparam int TOP_ENTRY   = 4095;
   localparam int CYCLE_LIMIT = 250000;
   localparam int PHASE_WORDS = 85;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [ENTRY_W-1:0] free_index;
      logic               found;
   } result_word_type;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type       kind;
      logic [CMD_W-1:0]   command;
      logic [ENTRY_W-1:0] value;
      logic               typed;
      result_word_type    answer;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en;
   logic [ENTRY_W-1:0] csr_wr_data;

   bfea_req_if req_bus ();
   bfea_rsp_if rsp_bus ();

   bitmap_free_entry_allocator_unit #(.MAP_WORDS(MAP_WORDS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   logic [WORD_BITS-1:0] usage_map [MAP_WORDS];
   logic [ENTRY_W-1:0]   search_floor;
   result_word_type      pending_answers [$];
   result_word_type      oldest_answer;
   int                   errors, words_sent, results_seen, cycle_count;
   int                   finds_hit, finds_miss, marks_sent, unused_sent, floor_writes;
   bit                   quiet_tail, long_hold_done;

   function automatic result_word_type apply_allocator_command(input logic [CMD_W-1:0] cmd,
                                                               input logic [ENTRY_W-1:0] idx);
      result_word_type ans;
      int              slot;
      int              k;
      ans = '0;
      slot = idx;
      if (cmd == CMD_MARK_USED || cmd == CMD_MARK_FREE) begin
         if (slot < ENTRY_LIMIT)
            usage_map[slot / WORD_BITS][WORD_BITS - 1 - slot % WORD_BITS] = (cmd == CMD_MARK_USED);
      end else if (cmd == CMD_FIND_FREE) begin
         for (k = search_floor; k < ENTRY_LIMIT && !ans.found; k++) begin
            if (!usage_map[k / WORD_BITS][WORD_BITS - 1 - k % WORD_BITS]) begin
               ans.free_index = ENTRY_W'(k);
               ans.found = 1'b1;
            end
         end
      end
      return ans;
   endfunction

   function automatic stim_row_type plan_row(input row_kind_type kind,
                                             input logic [CMD_W-1:0] cmd,
                                             input int value, input logic typed,
                                             input int want_index, input logic want_found);
      stim_row_type r;
      r.kind = kind;
      r.command = cmd;
      r.value = ENTRY_W'(value);
      r.typed = typed;
      r.answer.free_index = ENTRY_W'(want_index);
      r.answer.found = want_found;
      return r;
   endfunction

   function automatic logic [ENTRY_W-1:0] entry_near_floor();
      int k;
      k = search_floor + $urandom_range(0, 95);
      if (k > TOP_ENTRY)
         k = TOP_ENTRY - $urandom_range(0, 31);
      return ENTRY_W'(k);
   endfunction

   task automatic report_mismatch(input string note);
      $display("MISMATCH at word %0d: %s", results_seen, note);
      errors++;
   endtask

   // call at a falling edge; returns at the falling edge after the word is taken
   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [ENTRY_W-1:0] idx,
                            input logic typed, input result_word_type typed_answer,
                            output result_word_type answer);
      int gap;
      gap = 0;
      if (!quiet_tail && $urandom_range(0, 3) == 0)
         gap = $urandom_range(1, 15);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.command     <= cmd;
      req_bus.entry_index <= idx;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      answer = apply_allocator_command(cmd, idx);
      pending_answers.push_back(typed ? typed_answer : answer);
      words_sent++;
      if (cmd == CMD_FIND_FREE) begin
         if (answer.found)
            finds_hit++;
         else
            finds_miss++;
      end else if (cmd == CMD_UNUSED) begin
         unused_sent++;
      end else begin
         marks_sent++;
      end
      @(negedge clock);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (pending_answers.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_floor(input logic [ENTRY_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en    <= 1'b0;
      search_floor = value;
      floor_writes++;
   endtask

   task automatic run_random_phase(input logic [ENTRY_W-1:0] floor_value, input int word_count,
                                   input bit mid_pause);
      result_word_type ans;
      int              sent;
      int              pick;
      bit              paused;
      sent = 0;
      paused = 1'b0;
      drain();
      write_floor(floor_value);
      while (sent < word_count) begin
         if (mid_pause && !paused && sent >= word_count / 2) begin
            drain();
            paused = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            // allocate: find, then claim what was found
            send_word(CMD_FIND_FREE, ENTRY_W'($urandom_range(0, TOP_ENTRY)), 1'b0, '0, ans);
            sent++;
            if (ans.found) begin
               send_word(CMD_MARK_USED, ans.free_index, 1'b0, '0, ans);
               sent++;
            end
         end else if (pick < 55) begin
            send_word(CMD_MARK_FREE, entry_near_floor(), 1'b0, '0, ans);
            sent++;
         end else if (pick < 70) begin
            send_word(CMD_MARK_USED, entry_near_floor(), 1'b0, '0, ans);
            sent++;
         end else if (pick < 75) begin
            send_word(CMD_UNUSED, ENTRY_W'($urandom_range(0, TOP_ENTRY)), 1'b0, '0, ans);
            sent++;
         end else if (pick < 85) begin
            send_word(CMD_FIND_FREE, ENTRY_W'($urandom_range(0, TOP_ENTRY)), 1'b0, '0, ans);
            sent++;
         end else begin
            send_word(CMD_W'($urandom_range(0, 3)), ENTRY_W'($urandom_range(0, TOP_ENTRY)),
                      1'b0, '0, ans);
            sent++;
         end
      end
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d words still pending", cycle_count,
                  pending_answers.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_answers.size() == 0) begin
            report_mismatch($sformatf("unexpected word free_index %0d found %0b",
                                      rsp_bus.free_index, rsp_bus.found));
         end else begin
            oldest_answer = pending_answers.pop_front();
            if (rsp_bus.free_index !== oldest_answer.free_index)
               report_mismatch($sformatf("free_index %0d, expected %0d", rsp_bus.free_index,
                                         oldest_answer.free_index));
            if (rsp_bus.found !== oldest_answer.found)
               report_mismatch($sformatf("found %0b, expected %0b", rsp_bus.found,
                                         oldest_answer.found));
         end
         results_seen++;
      end
   end

   initial begin
      int hold;
      hold = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (hold > 0) begin
            rsp_bus.ready <= 1'b0;
            hold--;
         end else if (!long_hold_done && results_seen >= 120) begin
            // hold off long enough for the sender to back up
            long_hold_done = 1'b1;
            hold = 79;
            rsp_bus.ready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            hold = $urandom_range(1, 15) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      stim_row_type       directed_plan [$];
      result_word_type    ans;
      logic [ENTRY_W-1:0] floor_plan [8];
      int                 i;
      req_bus.valid       = 1'b0;
      req_bus.command     = CMD_MARK_USED;
      req_bus.entry_index = '0;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;
      search_floor        = '0;
      for (i = 0; i < MAP_WORDS; i++)
         usage_map[i] = '0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      directed_plan = '{
         plan_row(ROW_WORD, CMD_FIND_FREE, 4095, 1'b1, 0, 1'b1),
         plan_row(ROW_WORD, CMD_MARK_USED, 0, 1'b1, 0, 1'b0),
         plan_row(ROW_WORD, CMD_FIND_FREE, 0, 1'b1, 1, 1'b1),
         plan_row(ROW_WORD, CMD_MARK_USED, 4095, 1'b1, 0, 1'b0),
         plan_row(ROW_WORD, CMD_UNUSED, 4095, 1'b1, 0, 1'b0),
         plan_row(ROW_WORD, CMD_MARK_USED, 1, 1'b1, 0, 1'b0),
         plan_row(ROW_WORD, CMD_MARK_USED, 1, 1'b1, 0, 1'b0),
         plan_row(ROW_WORD, CMD_FIND_FREE, 12'h555, 1'b1, 2, 1'b1),
         plan_row(ROW_WORD, CMD_MARK_FREE, 0, 1'b1, 0, 1'b0),
         plan_row(ROW_WORD, CMD_MARK_FREE, 0, 1'b1, 0, 1'b0),
         plan_row(ROW_WORD, CMD_FIND_FREE, 12'hAAA, 1'b1, 0, 1'b1),
         plan_row(ROW_CSR, CMD_MARK_USED, 33, 1'b0, 0, 1'b0),
         plan_row(ROW_WORD, CMD_MARK_USED, 33, 1'b1, 0, 1'b0),
         plan_row(ROW_WORD, CMD_FIND_FREE, 0, 1'b1, 34, 1'b1),
         plan_row(ROW_WORD, CMD_MARK_USED, 2, 1'b0, 0, 1'b0),
         plan_row(ROW_WORD, CMD_FIND_FREE, 33, 1'b0, 0, 1'b0),
         plan_row(ROW_CSR, CMD_MARK_USED, 4095, 1'b0, 0, 1'b0),
         plan_row(ROW_WORD, CMD_FIND_FREE, 0, 1'b1, 0, 1'b0),
         plan_row(ROW_WORD, CMD_MARK_FREE, 4095, 1'b1, 0, 1'b0),
         plan_row(ROW_WORD, CMD_FIND_FREE, 4095, 1'b1, 4095, 1'b1),
         plan_row(ROW_CSR, CMD_MARK_USED, 0, 1'b0, 0, 1'b0),
         plan_row(ROW_WORD, CMD_FIND_FREE, 0, 1'b0, 0, 1'b0),
         plan_row(ROW_WORD, CMD_MARK_FREE, 1, 1'b0, 0, 1'b0)
      };

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_CSR) begin
            drain();
            write_floor(directed_plan[i].value);
         end else begin
            send_word(directed_plan[i].command, directed_plan[i].value, directed_plan[i].typed,
                      directed_plan[i].answer, ans);
         end
      end

      floor_plan = '{12'd0, 12'd4064, ENTRY_W'($urandom_range(0, TOP_ENTRY)), 12'd4095,
                     12'd31, ENTRY_W'($urandom_range(0, 511)), 12'd4000, 12'd0};
      for (i = 0; i < 8; i++) begin
         if (i == 7)
            quiet_tail = 1'b1;
         run_random_phase(floor_plan[i], PHASE_WORDS, i == 2);
      end

      drain();
      repeat (10) @(posedge clock);

      $display("Sent %0d words over %0d search floors: %0d marks, %0d unused codes.",
               words_sent, floor_writes, marks_sent, unused_sent);
      $display("Finds: %0d located an entry, %0d found none; %0d results checked, %0d errors.",
               finds_hit, finds_miss, results_seen, errors);
      if (errors == 0 && pending_answers.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
